@@ hdl/fst_pkg.sv @@
package fst_pkg;

  localparam int MAX_FRAMES_DEF = 16;

  localparam int COORD_W = 16;
  localparam int DUR_W   = 16;
  localparam int TIME_W  = 17;
  localparam int FIDX_W  = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [DUR_W-1:0]   elapsed_ms;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [DUR_W-1:0]   duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] shown_x;
    logic [COORD_W-1:0] shown_y;
    logic [COORD_W-1:0] shown_width;
    logic [COORD_W-1:0] shown_height;
    logic [FIDX_W-1:0]  frame_index;
    logic               finished;
    logic               append_dropped;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    rect_t            rect;
  } frame_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_STEP   = 4'b0010,
    ST_ISSUE  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

endpackage

@@ hdl/fst_frame_mem.sv @@
module fst_frame_mem
  import fst_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  frame_entry_t     wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output frame_entry_t     rd_data
);

  frame_entry_t mem [MAX_FRAMES];
  frame_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/fst_ctrl.sv @@
module fst_ctrl
  import fst_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_item,
  output logic             in_ready,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output frame_entry_t     mem_wr_data,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  frame_entry_t     mem_rd_data,
  output logic             res_valid,
  output out_item_t        res_item,
  input  logic             res_ready
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [IDX_W-1:0]  cf_r, cf_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              done_r, done_nxt;
  logic              drop_r, drop_nxt;
  logic              loop_r;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] dur;
  logic [CNT_W-1:0]  cf_inc;
  logic              full;

  assign sum    = {1'b0, time_r} + {2'b00, in_item.elapsed_ms};
  assign dur    = (mem_rd_data.dur == '0) ? TIME_W'(1) : {1'b0, mem_rd_data.dur};
  assign cf_inc = CNT_W'(cf_r) + CNT_W'(1);
  assign full   = (loaded_r == CNT_W'(MAX_FRAMES));

  assign in_ready    = (state_r == ST_IDLE);
  assign mem_wr_addr = loaded_r[IDX_W-1:0];
  assign mem_wr_data = '{dur: in_item.duration_ms,
                         rect: '{x: in_item.rect_x, y: in_item.rect_y,
                                 w: in_item.rect_width, h: in_item.rect_height}};
  assign mem_rd_addr = cf_nxt;

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    cf_nxt     = cf_r;
    time_nxt   = time_r;
    done_nxt   = done_r;
    drop_nxt   = drop_r;
    mem_wr_en  = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          drop_nxt  = 1'b0;
          state_nxt = ST_ISSUE;
          priority if (in_item.mode == MODE_TICK) begin
            if (loaded_r != '0) begin
              time_nxt  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
              state_nxt = ST_STEP;
            end
          end else if (in_item.mode == MODE_APPEND) begin
            if (!full) begin
              mem_wr_en  = 1'b1;
              loaded_nxt = loaded_r + CNT_W'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else if (in_item.mode == MODE_RESTART) begin
            cf_nxt   = '0;
            time_nxt = '0;
            done_nxt = 1'b0;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_STEP: begin
        if (time_r < dur) begin
          state_nxt = ST_RESULT;
        end else begin
          time_nxt = time_r - dur;
          priority if (cf_inc < loaded_r) begin
            cf_nxt = cf_inc[IDX_W-1:0];
          end else if (loop_r) begin
            cf_nxt = '0;
          end else begin
            done_nxt  = 1'b1;
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_item = '0;
    if (loaded_r != '0) begin
      res_item.shown_x      = mem_rd_data.rect.x;
      res_item.shown_y      = mem_rd_data.rect.y;
      res_item.shown_width  = mem_rd_data.rect.w;
      res_item.shown_height = mem_rd_data.rect.h;
    end
    res_item.frame_index    = FIDX_W'(cf_r);
    res_item.finished       = done_r & ~loop_r;
    res_item.append_dropped = drop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= '0;
      cf_r     <= '0;
      time_r   <= '0;
      done_r   <= 1'b0;
      drop_r   <= 1'b0;
      loop_r   <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      cf_r     <= cf_nxt;
      time_r   <= time_nxt;
      done_r   <= done_nxt;
      drop_r   <= drop_nxt;
      if (cfg_wr_en) begin
        loop_r <= cfg_wr_data;
      end
    end
  end

  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_FRAMES))
    else $error("frame count exceeds table size");

  a_cf_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(cf_r) < loaded_r) || (cf_r == '0))
    else $error("current frame outside loaded table");

  a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (loaded_r != '0))
    else $error("stepping with empty table");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == ST_IDLE) && in_valid && !full)
    else $error("table write outside append transaction");

  a_write_then_issue: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> (state_r == ST_ISSUE))
    else $error("result read may miss a fresh table write");

endmodule

@@ hdl/frame_sequence_timer.sv @@
// Channel  | Ports                         | Transaction
// in       | in_valid, in_stall, in_item   | one tick, append, restart or unused
// out      | out_valid, out_stall, out_item| current frame, index, flags
// cfg      | cfg_wr_en, cfg_wr_data        | loop_enable write
//
// Append, restart and unused modes pass from accept through ISSUE to RESULT.
// A tick on a loaded table stays in STEP, one memory read per frame it passes.
// One transaction is in work at a time; the output register frees the input side.
// Reset is synchronous; the frame table has no reset and needs no clearing pass.
// A stalled result holds in the output register; the next one waits behind it.
module frame_sequence_timer
  import fst_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic             in_ready;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  frame_entry_t     mem_wr_data;
  logic [IDX_W-1:0] mem_rd_addr;
  frame_entry_t     mem_rd_data;
  logic             res_valid;
  out_item_t        res_item;
  logic             res_ready;

  logic             out_valid_r;
  out_item_t        out_item_r;

  assign in_stall  = ~in_ready;
  assign res_ready = ~out_valid_r | ~out_stall;

  fst_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .in_ready    (in_ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_item    (res_item),
    .res_ready   (res_ready)
  );

  fst_frame_mem #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fst_pkg::*;

  localparam int MAX_FRAMES = MAX_FRAMES_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int STEP_CAP = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  rect_t frame_tbl[MAX_FRAMES];
  bit [DUR_W-1:0] dur_tbl[MAX_FRAMES];
  int loaded = 0;
  int cur = 0;
  int tif = 0;
  bit done = 1'b0;
  bit loop_on = 1'b1;

  out_item_t pending_frames[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  frame_sequence_timer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int frame_time(int idx);
    return (dur_tbl[idx] == 0) ? 1 : int'(dur_tbl[idx]);
  endfunction

  function automatic int advance(ref int c, ref int t, ref bit d, input int elapsed,
                                 input int cap);
    int n = 0;
    if (loaded == 0) return 0;
    t = t + elapsed;
    if (t > int'(TIME_MAX)) t = int'(TIME_MAX);
    while (t >= frame_time(c) && n < cap) begin
      t -= frame_time(c);
      n++;
      if (c + 1 < loaded) begin
        c++;
      end else if (loop_on) begin
        c = 0;
      end else begin
        d = 1'b1;
        c = loaded - 1;
        break;
      end
    end
    return n;
  endfunction

  function automatic out_item_t predict_frame(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.mode)
      MODE_TICK: void'(advance(cur, tif, done, int'(it.elapsed_ms), 32'h7fffffff));
      MODE_APPEND: begin
        if (loaded < MAX_FRAMES) begin
          frame_tbl[loaded] = '{x: it.rect_x, y: it.rect_y, w: it.rect_width,
                                h: it.rect_height};
          dur_tbl[loaded] = it.duration_ms;
          loaded++;
        end else begin
          r.append_dropped = 1'b1;
        end
      end
      MODE_RESTART: begin
        cur = 0;
        tif = 0;
        done = 1'b0;
      end
      default: ;
    endcase
    if (loaded != 0) begin
      r.shown_x = frame_tbl[cur].x;
      r.shown_y = frame_tbl[cur].y;
      r.shown_width = frame_tbl[cur].w;
      r.shown_height = frame_tbl[cur].h;
    end
    r.frame_index = cur[FIDX_W-1:0];
    r.finished = done & ~loop_on;
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] mode, int elapsed, int x, int y,
                                         int w, int h, int dur);
    in_item_t it;
    it.mode = mode;
    it.elapsed_ms = elapsed[DUR_W-1:0];
    it.rect_x = x[COORD_W-1:0];
    it.rect_y = y[COORD_W-1:0];
    it.rect_width = w[COORD_W-1:0];
    it.rect_height = h[COORD_W-1:0];
    it.duration_ms = dur[DUR_W-1:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r, s, el, c2, t2;
    bit d2;
    it = make_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < ((loaded < MAX_FRAMES) ? 20 : 4)) begin
      it.mode = MODE_APPEND;
      case ($urandom_range(0, 3))
        0: it.duration_ms = DUR_W'($urandom_range(0, 3));
        1: it.duration_ms = DUR_W'($urandom_range(0, 60));
        2: it.duration_ms = DUR_W'($urandom_range(0, 2000));
        default: ;
      endcase
    end else if (r < 30) begin
      it.mode = MODE_RESTART;
    end else if (r < 33) begin
      it.mode = MODE_UNUSED;
    end else begin
      s = 0;
      for (int i = 0; i < loaded; i++) s += frame_time(i);
      case ($urandom_range(0, 9))
        0: el = int'(it.elapsed_ms);
        1, 2: el = $urandom_range(0, 10);
        3, 4, 5: el = $urandom_range(0, (loaded != 0) ? 2 * frame_time(cur) : 100);
        default: el = $urandom_range(0, (2 * s > 65535) ? 65535 : 2 * s);
      endcase
      c2 = cur;
      t2 = tif;
      d2 = done;
      if (advance(c2, t2, d2, el, STEP_CAP) >= STEP_CAP) begin
        el = $urandom_range(0, 3);
        c2 = cur;
        t2 = tif;
        d2 = done;
        if (advance(c2, t2, d2, el, STEP_CAP) >= STEP_CAP) it.mode = MODE_RESTART;
      end
      it.elapsed_ms = el[DUR_W-1:0];
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_frames = {pending_frames, predict_frame(it)};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_loop(bit value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    loop_on = value;
  endtask

  task automatic test_empty_table();
    send_item(make_item(MODE_TICK, 65535, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_TICK, 0, 65535, 65535, 65535, 65535, 65535));
    send_item(make_item(MODE_RESTART, 0, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_UNUSED, 65535, 65535, 65535, 65535, 65535, 65535));
  endtask

  task automatic test_append_frames();
    send_item(make_item(MODE_APPEND, 65535, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_APPEND, 0, 65535, 65535, 65535, 65535, 65535));
    send_item(make_item(MODE_APPEND, 0, $urandom, $urandom, $urandom, $urandom, 3));
    send_item(make_item(MODE_APPEND, 0, $urandom, $urandom, $urandom, $urandom, 1));
  endtask

  task automatic test_loop_ticks();
    send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_TICK, 1, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_TICK, 65535, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_TICK, 2, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_TICK, 2, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_TICK, 5, 0, 0, 0, 0, 0));
  endtask

  task automatic test_restart();
    send_item(make_item(MODE_RESTART, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_stop_at_end();
    set_loop(1'b0);
    repeat (4) send_item(make_item(MODE_TICK, 65535, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_UNUSED, 0, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_RESTART, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_phase(int count, bit loop_value, bit quiet);
    set_loop(loop_value);
    no_idle = quiet;
    repeat (count) send_item(random_item());
    no_idle = 1'b0;
  endtask

  task automatic test_table_full();
    in_item_t it;
    while (loaded < MAX_FRAMES) begin
      it = random_item();
      it.mode = MODE_APPEND;
      send_item(it);
    end
    send_item(make_item(MODE_APPEND, 0, 65535, 65535, 65535, 65535, 0));
    send_item(make_item(MODE_APPEND, 0, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic test_backpressure();
    set_loop(1'b1);
    no_idle = 1'b1;
    hold_ticket++;
    repeat (40) send_item(random_item());
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 21);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_frame;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result transaction: %h", out_item);
      end else begin
        exp_frame = pending_frames.pop_front();
        if (out_item.shown_x !== exp_frame.shown_x ||
            out_item.shown_y !== exp_frame.shown_y ||
            out_item.shown_width !== exp_frame.shown_width ||
            out_item.shown_height !== exp_frame.shown_height ||
            out_item.frame_index !== exp_frame.frame_index ||
            out_item.finished !== exp_frame.finished ||
            out_item.append_dropped !== exp_frame.append_dropped) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: exp x=%h y=%h w=%h h=%h idx=%0d fin=%b drop=%b",
                     exp_frame.shown_x, exp_frame.shown_y, exp_frame.shown_width,
                     exp_frame.shown_height, exp_frame.frame_index, exp_frame.finished,
                     exp_frame.append_dropped);
            $display("          got x=%h y=%h w=%h h=%h idx=%0d fin=%b drop=%b",
                     out_item.shown_x, out_item.shown_y, out_item.shown_width,
                     out_item.shown_height, out_item.frame_index, out_item.finished,
                     out_item.append_dropped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("** frame_sequence_timer: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_append_frames();
    test_loop_ticks();
    test_restart();
    test_stop_at_end();
    test_random_phase(250, 1'b1, 1'b0);
    test_table_full();
    test_random_phase(200, 1'b0, 1'b0);
    test_random_phase(200, 1'b1, 1'b1);
    test_random_phase(150, 1'b0, 1'b0);
    test_backpressure();
    test_random_phase(180, 1'b1, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("** frame_sequence_timer: PASSED **");
    end else begin
      $display("** frame_sequence_timer: FAILED **");
    end
    $finish;
  end

endmodule
